>>> hw/rtl/vre_pkg.sv
// shared types and constants for the value rank encoder
`default_nettype none

package vre_pkg;

    localparam int DataW      = 32;
    localparam int StoreDepth = 64;
    localparam int AddrW      = $clog2(StoreDepth);
    localparam int CountW     = AddrW + 1;
    localparam int RankW      = 6;
    localparam int OutTdataW  = ((RankW + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } vre_state_t;

    // access request from the sequencer to the value store
    typedef struct packed {
        logic                    wr_en;
        logic [AddrW-1:0]        wr_addr;
        logic signed [DataW-1:0] wr_data;
        logic [AddrW-1:0]        rd_addr_a;
        logic [AddrW-1:0]        rd_addr_b;
    } vre_store_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/vre_store.sv
// value store: one write port, two registered read ports
`default_nettype none

module vre_store (
    input  wire logic                             aclk,
    input  wire vre_pkg::vre_store_req_t          req,
    output logic signed [vre_pkg::DataW-1:0]      rd_data_a,
    output logic signed [vre_pkg::DataW-1:0]      rd_data_b
);
    import vre_pkg::*;

    logic signed [DataW-1:0] mem [StoreDepth];
    logic signed [DataW-1:0] rd_a_reg;
    logic signed [DataW-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_a_reg <= mem[req.rd_addr_a];
        rd_b_reg <= mem[req.rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

>>> hw/rtl/vre_seq.sv
// sequencer: batch loading, shared compare and count unit, result register
`default_nettype none

module vre_seq #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic signed [vre_pkg::DataW-1:0]    s_value,
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [vre_pkg::RankW-1:0]                m_rank,
    output logic                                     m_last,
    output logic                                     m_overflow,
    output vre_pkg::vre_store_req_t                  store_req,
    input  wire logic signed [vre_pkg::DataW-1:0]    rd_data_a,
    input  wire logic signed [vre_pkg::DataW-1:0]    rd_data_b
);
    import vre_pkg::*;

    localparam logic [CountW-1:0] MaxCount = CountW'(MAX_ITEMS);

    vre_state_t         state_reg, state_next;
    logic [CountW-1:0]  count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [AddrW-1:0]   last_idx_reg, last_idx_next;
    logic [AddrW-1:0]   i_reg, i_next;
    logic [AddrW-1:0]   j_reg, j_next;
    logic               pend_reg, pend_next;
    logic [RankW-1:0]   smaller_reg, smaller_next;
    logic               out_valid_reg, out_valid_next;
    logic [RankW-1:0]   out_rank_reg, out_rank_next;
    logic               out_last_reg, out_last_next;
    logic               out_ovf_reg, out_ovf_next;
    logic               stored;
    logic [CountW-1:0]  count_new;
    logic               cmp_lt;

    // the one comparator shared by every pair
    assign cmp_lt = rd_data_b < rd_data_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_idx_reg <= last_idx_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        smaller_reg  <= smaller_next;
        out_rank_reg <= out_rank_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        last_idx_next  = last_idx_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        pend_next      = 1'b0;
        smaller_next   = smaller_reg;
        out_valid_next = out_valid_reg;
        out_rank_next  = out_rank_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        s_tready       = 1'b0;
        stored         = 1'b0;
        count_new      = count_reg;

        store_req.wr_en     = 1'b0;
        store_req.wr_addr   = count_reg[AddrW-1:0];
        store_req.wr_data   = s_value;
        store_req.rd_addr_a = i_reg;
        store_req.rd_addr_b = j_reg;

        // count the compare issued last cycle
        if (pend_reg && cmp_lt) begin
            smaller_next = smaller_reg + RankW'(1);
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (count_reg < MaxCount) begin
                        store_req.wr_en = 1'b1;
                        stored          = 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    count_new  = count_reg + CountW'(stored);
                    count_next = count_new;
                    if (s_tlast) begin
                        last_idx_next = AddrW'(count_new - CountW'(1));
                        i_next        = '0;
                        j_next        = '0;
                        smaller_next  = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                pend_next = 1'b1;
                j_next    = j_reg + AddrW'(1);
                if (j_reg == last_idx_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_rank_next  = smaller_reg;
                    out_last_next  = (i_reg == last_idx_reg);
                    out_ovf_next   = ovf_reg;
                    smaller_next   = '0;
                    j_next         = '0;
                    if (i_reg == last_idx_reg) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        i_next     = i_reg + AddrW'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign m_tvalid   = out_valid_reg;
    assign m_rank     = out_rank_reg;
    assign m_last     = out_last_reg;
    assign m_overflow = out_ovf_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MaxCount)
        else $error("stored count beyond capacity");

    a_full_sets_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD && s_tvalid && count_reg == MaxCount) |=> ovf_reg)
        else $error("dropped item did not raise overflow");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (j_reg <= last_idx_reg && i_reg <= last_idx_reg))
        else $error("scan index past the batch");

    a_write_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        store_req.wr_en |-> (state_reg == ST_LOAD && s_tvalid))
        else $error("store written outside loading");

endmodule

`default_nettype wire

>>> hw/rtl/value_rank_encoder.sv
// a loading item is taken as soon as it is valid; the closing item starts ranking
// each of the n stored values is ranked on the one comparator by n reads of the
// second store port, then a drain state for the registered read, then emit; emit
// waits while the result side stalls; the input is not ready while ranking runs
// reset clears the sequencer, count and overflow flag; the store is not cleared
// and no entry is compared before it is written
`default_nettype none

module value_rank_encoder #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [vre_pkg::DataW-1:0]         s_tdata,   // [31:0] value
    input  wire logic                              s_tlast,   // is_last
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [vre_pkg::OutTdataW-1:0]          m_tdata,   // [5:0] rank, rest zero
    output logic                                   m_tlast,   // last_rank
    output logic [0:0]                             m_tuser    // [0] overflow
);
    import vre_pkg::*;

    vre_store_req_t          store_req;
    logic signed [DataW-1:0] rd_data_a;
    logic signed [DataW-1:0] rd_data_b;
    logic [RankW-1:0]        rank;
    logic                    overflow;

    vre_store u_store (
        .aclk      (aclk),
        .req       (store_req),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    vre_seq #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_value    (signed'(s_tdata)),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_rank     (rank),
        .m_last     (m_tlast),
        .m_overflow (overflow),
        .store_req  (store_req),
        .rd_data_a  (rd_data_a),
        .rd_data_b  (rd_data_b)
    );

    assign m_tdata = OutTdataW'(rank);
    assign m_tuser = overflow;

endmodule

`default_nettype wire

>>> tb/value_rank_encoder_tb.sv
// self-checking testbench for the value rank encoder: batches in, ranks checked against a predictor
`default_nettype none

module value_rank_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vre_pkg::*;

    localparam int BatchCap   = 64;
    localparam int StallLimit = 20000;
    localparam int TailCycles = BatchCap * (BatchCap + 2) + 100;

    typedef struct packed {
        logic [RankW-1:0] rank;
        logic             last_rank;
        logic             overflow;
    } rank_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    wire                  s_tready;
    logic [DataW-1:0]     s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    wire                  m_tvalid;
    logic                 m_tready = 1'b0;
    wire [OutTdataW-1:0]  m_tdata;
    wire                  m_tlast;
    wire [0:0]            m_tuser;

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int          err_count    = 0;
    int          stall_cycles = 0;

    // ranks the block still owes, oldest first
    rank_result_t expected_ranks[$];

    // predictor copy of the open batch
    logic signed [DataW-1:0] batch_vals [BatchCap];
    int unsigned             batch_len     = 0;
    logic                    batch_dropped = 1'b0;

    value_rank_encoder #(
        .MAX_ITEMS(BatchCap)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always #6 aclk = ~aclk;

    function automatic void absorb_value(input logic signed [DataW-1:0] v, input logic closes);
        int unsigned  smaller;
        rank_result_t r;
        if (batch_len < BatchCap) begin
            batch_vals[batch_len] = v;
            batch_len++;
        end else begin
            batch_dropped = 1'b1;
        end
        if (closes) begin
            // rank = count of strictly smaller stored values
            for (int i = 0; i < batch_len; i++) begin
                smaller = 0;
                for (int j = 0; j < batch_len; j++) begin
                    if (batch_vals[j] < batch_vals[i]) smaller++;
                end
                r.rank      = smaller[RankW-1:0];
                r.last_rank = (i == batch_len - 1);
                r.overflow  = batch_dropped;
                expected_ranks.push_back(r);
            end
            batch_len     = 0;
            batch_dropped = 1'b0;
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        err_count++;
        if (err_count <= 10) $display("mismatch: %s", msg);
    endfunction

    function automatic logic [DataW-1:0] pick_value();
        logic [DataW-1:0] corner [5];
        corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1};
        case ($urandom_range(3))
            0, 1:    return $urandom;
            2:       return corner[$urandom_range(4)];
            default: return 32'($urandom_range(8)) - 32'd4;  // narrow range for ties
        endcase
    endfunction

    task automatic send_item(input logic [DataW-1:0] v, input logic closes);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= closes;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        absorb_value(v, closes);
    endtask

    task automatic send_batch(input logic [DataW-1:0] vals[$]);
        foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_ranks.size() != 0);
    endtask

    task automatic test_extremes();
        logic [DataW-1:0] vals[$];
        vals = {32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1};
        send_batch(vals);
        // single item batch
        vals = {32'h1234_5678};
        send_batch(vals);
        hold_until_drained();
    endtask

    task automatic test_ties();
        logic [DataW-1:0] vals[$];
        vals = {32'd5, 32'd5, 32'hffff_fffd, 32'd5, 32'hffff_fffd, 32'h8000_0000,
                32'h8000_0000};
        send_batch(vals);
    endtask

    task automatic test_full_batch();
        logic [DataW-1:0] vals[$];
        repeat (BatchCap) vals.push_back(pick_value());
        send_batch(vals);
    endtask

    task automatic test_overflow();
        logic [DataW-1:0] vals[$];
        // closing item lands after the store is full and is dropped
        repeat (BatchCap + $urandom_range(1, 3)) vals.push_back(pick_value());
        send_batch(vals);
    endtask

    task automatic test_random_batches(input int unsigned n_items);
        int unsigned      sent;
        int unsigned      len;
        logic [DataW-1:0] vals[$];
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            vals.delete();
            repeat (len) vals.push_back(pick_value());
            send_batch(vals);
            sent += len;
            if ($urandom_range(9) == 0) hold_until_drained();
        end
    endtask

    always @(posedge aclk) begin : rank_check
        rank_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_ranks.size() == 0) begin
                note_mismatch($sformatf("unexpected result tdata=%0h last=%0b ovf=%0b",
                                        m_tdata, m_tlast, m_tuser[0]));
            end else begin
                exp_r = expected_ranks.pop_front();
                if (m_tdata !== OutTdataW'(exp_r.rank))
                    note_mismatch($sformatf("rank exp %0d got %0d", exp_r.rank, m_tdata));
                if (m_tlast !== exp_r.last_rank)
                    note_mismatch($sformatf("last exp %0b got %0b", exp_r.last_rank, m_tlast));
                if (m_tuser[0] !== exp_r.overflow)
                    note_mismatch($sformatf("overflow exp %0b got %0b", exp_r.overflow,
                                            m_tuser[0]));
            end
        end
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    initial begin : watchdog
        while (stall_cycles < StallLimit) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("[value_rank_encoder] ERROR");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 33;
        snk_idle_pct = 83;
        test_extremes();
        test_ties();
        test_random_batches(3);

        src_idle_pct = 83;
        snk_idle_pct = 33;
        test_full_batch();
        test_overflow();
        test_random_batches(3);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_batches(3);

        hold_until_drained();
        repeat (TailCycles) @(posedge aclk);
        if (err_count == 0 && expected_ranks.size() == 0) begin
            $display("[value_rank_encoder] OK");
        end else begin
            $display("[value_rank_encoder] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/vre_pkg.sv
hw/rtl/vre_store.sv
hw/rtl/vre_seq.sv
hw/rtl/value_rank_encoder.sv
tb/value_rank_encoder_tb.sv
